// ===== src/dbmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory block map checker package
// Shared types, constants and the character test used by the checker blocks.
// ----------------------------------------------------------------------------
package dbmc_pkg;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_DATA_W  = 224;
	localparam int OUT_DATA_W = 8;

	// Bitmap memory row width; a row holds this many block marks.
	localparam int ROW_BITS = 32;
	localparam int BIT_AW   = 5;

	// Configuration register indexes.
	localparam logic [1:0] REG_DISK_SIZE   = 2'd0;
	localparam logic [1:0] REG_BLOCK_SHIFT = 2'd1;
	localparam logic [1:0] REG_DIR_ENTRIES = 2'd2;
	localparam logic [1:0] REG_WIDE_PTRS   = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [31:0] DISK_SIZE_RST   = 32'd256256;
	localparam logic [3:0]  BLOCK_SHIFT_RST = 4'd10;
	localparam logic [11:0] DIR_ENTRIES_RST = 12'd64;

	// Error and status codes.
	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_DIR      = 2'd2;
	localparam logic [1:0] ERR_SHARED   = 2'd3;

	// Status byte of a deleted entry.
	localparam logic [7:0] DELETED_MARK = 8'hE5;

	// Last pointer index for each pointer format.
	localparam logic [3:0] PTRS_WIDE_M1   = 4'd7;
	localparam logic [3:0] PTRS_NARROW_M1 = 4'd15;

	typedef struct packed {
		logic [31:0] disk_size_bytes;
		logic [3:0]  block_shift;
		logic [11:0] dir_entry_count;
		logic        wide_pointers;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
		logic clear;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       in_use;
		logic       last;
		logic [3:0] ptr_last;
		logic       clear_done;
		logic       out_free;
	} stat_t;

	// A name or extension character is refused when, masked to seven bits,
	// it is a control character or one of < > . , ; : = ? * [ ].
	function automatic logic char_ok(input logic [7:0] c);
		logic [6:0] c7;
		c7 = c[6:0];
		return !((c7 < 7'h20) || (c7 == 7'h3C) || (c7 == 7'h3E) || (c7 == 7'h2E) ||
			(c7 == 7'h2C) || (c7 == 7'h3B) || (c7 == 7'h3A) || (c7 == 7'h3D) ||
			(c7 == 7'h3F) || (c7 == 7'h2A) || (c7 == 7'h5B) || (c7 == 7'h5D));
	endfunction

endpackage

// ===== src/dbmc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dbmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== src/dbmc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory block map checker configuration registers
// Holds the disk geometry and pointer format written over the register port.
// ----------------------------------------------------------------------------
module dbmc_cfg import dbmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes, one register per accepted write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.disk_size_bytes <= DISK_SIZE_RST;
			cfg_q.block_shift     <= BLOCK_SHIFT_RST;
			cfg_q.dir_entry_count <= DIR_ENTRIES_RST;
			cfg_q.wide_pointers   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DISK_SIZE:   cfg_q.disk_size_bytes <= cfg_data;
				REG_BLOCK_SHIFT: cfg_q.block_shift     <= cfg_data[3:0];
				REG_DIR_ENTRIES: cfg_q.dir_entry_count <= cfg_data[11:0];
				REG_WIDE_PTRS:   cfg_q.wide_pointers   <= cfg_data[0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

// ===== src/dbmc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory block map checker controller
// Sequences entry load, pointer steps, result hand-over and bitmap clearing.
// ----------------------------------------------------------------------------
module dbmc_ctrl import dbmc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [3:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	// Commands for the current state.
	always_comb begin
		cmd        = '0;
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.step   = (state_q == ST_RUN) && stat.in_use;
		cmd.finish = (state_q == ST_FIN) && stat.out_free;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (stat.clear_done) begin
				state_d = ST_IDLE;
			end
			ST_IDLE: if (in_valid) begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (!stat.in_use) begin
					state_d = ST_FIN;
				end else if (cnt_q == stat.ptr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN: if (stat.out_free) begin
				state_d = stat.last ? ST_CLEAR : ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// State and pointer counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

endmodule

// ===== src/dbmc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory block map checker datapath
// Entry test, pointer bounds checks, bitmap read-modify-write and result.
// ----------------------------------------------------------------------------
module dbmc_dp import dbmc_pkg::*; #(
	parameter int MAP_BLOCKS = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  cfg_t                  cfg,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic                  in_last,
	output stat_t                 stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_last
);

	localparam int ROWS   = (MAP_BLOCKS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_AW = $clog2(ROWS);

	// Input fields.
	logic [7:0]   entry_status;
	logic [63:0]  name_chars;
	logic [23:0]  ext_chars;
	logic [127:0] pointers;

	assign entry_status = in_data[7:0];
	assign name_chars   = in_data[71:8];
	assign ext_chars    = in_data[95:72];
	assign pointers     = in_data[223:96];

	// Entry test on the status byte and the eleven name characters.
	logic entry_ok;
	always_comb begin
		entry_ok = (entry_status != DELETED_MARK);
		for (int i = 0; i < 8; i++) begin
			if (!char_ok(name_chars[8*i +: 8])) begin
				entry_ok = 1'b0;
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (!char_ok(ext_chars[8*i +: 8])) begin
				entry_ok = 1'b0;
			end
		end
	end

	// Disk geometry: highest block and directory blocks, rounded up.
	logic [31:0] max_blk;
	logic [16:0] dir_bytes;
	logic [16:0] dir_mask;
	logic [16:0] dir_blks;
	assign max_blk   = cfg.disk_size_bytes >> cfg.block_shift;
	assign dir_bytes = {cfg.dir_entry_count, 5'b0};
	assign dir_mask  = (17'd1 << cfg.block_shift) - 17'd1;
	assign dir_blks  = (dir_bytes >> cfg.block_shift) + 17'(|(dir_bytes & dir_mask));

	// Entry registers.
	logic [127:0] ptr_q;
	logic         wide_q;
	logic         in_use_q;
	logic         last_q;
	logic [31:0]  max_blk_q;
	logic [16:0]  dir_blks_q;
	logic [1:0]   err_q;
	logic         shared_q;

	// Current pointer and its bitmap position.
	logic [15:0]       ptr;
	logic              track;
	logic [10:0]       row_full;
	logic [ROW_AW-1:0] row;
	assign ptr      = wide_q ? ptr_q[15:0] : {8'h00, ptr_q[7:0]};
	assign track    = (ptr != 16'd0) && ({1'b0, ptr} < 17'(MAP_BLOCKS));
	assign row_full = ptr[15:BIT_AW];
	assign row      = row_full[ROW_AW-1:0];

	// Bitmap stage one registers.
	logic              track_s1;
	logic [ROW_AW-1:0] row_s1;
	logic [BIT_AW-1:0] bit_s1;

	// Forwarding of the previous write, which the next read cannot yet see.
	logic                fwd_valid_q;
	logic [ROW_AW-1:0]   fwd_row_q;
	logic [ROW_BITS-1:0] fwd_data_q;

	logic [ROW_AW-1:0]   clr_row_q;
	logic [ROW_BITS-1:0] rd_data;
	logic [ROW_BITS-1:0] row_data;
	logic [ROW_BITS-1:0] row_new;
	logic                was_set;
	logic                wr_en;
	logic [ROW_AW-1:0]   wr_addr;
	logic [ROW_BITS-1:0] wr_data;

	assign row_data = (fwd_valid_q && (fwd_row_q == row_s1)) ? fwd_data_q : rd_data;
	assign was_set  = row_data[bit_s1];
	assign row_new  = row_data | (ROW_BITS'(1) << bit_s1);

	// Write port: clearing pass or mark of the pointer in stage one.
	always_comb begin
		wr_en   = cmd.clear || track_s1;
		wr_addr = cmd.clear ? clr_row_q : row_s1;
		wr_data = cmd.clear ? '0 : row_new;
	end

	dbmc_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(ROWS)
	) u_map (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(row),
		.rd_data(rd_data)
	);

	// Entry load, pointer walk and bounds checks.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ptr_q      <= pointers;
			wide_q     <= cfg.wide_pointers;
			last_q     <= in_last;
			max_blk_q  <= max_blk;
			dir_blks_q <= dir_blks;
		end else if (cmd.step) begin
			ptr_q <= wide_q ? (ptr_q >> 16) : (ptr_q >> 8);
		end
		row_s1     <= row;
		bit_s1     <= ptr[BIT_AW-1:0];
		fwd_row_q  <= row_s1;
		fwd_data_q <= row_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q    <= 1'b0;
			err_q       <= ERR_OK;
			shared_q    <= 1'b0;
			track_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			clr_row_q   <= '0;
		end else begin
			track_s1    <= cmd.step && track;
			fwd_valid_q <= track_s1;
			if (cmd.load) begin
				in_use_q <= entry_ok;
				err_q    <= ERR_OK;
				shared_q <= 1'b0;
			end else begin
				if (cmd.step && (err_q == ERR_OK)) begin
					if ({16'h0000, ptr} > max_blk_q) begin
						err_q <= ERR_OVERFLOW;
					end else if ((ptr != 16'd0) && ({1'b0, ptr} < dir_blks_q)) begin
						err_q <= ERR_DIR;
					end
				end
				if (track_s1 && was_set) begin
					shared_q <= 1'b1;
				end
			end
			if (cmd.clear) begin
				clr_row_q <= (clr_row_q == ROW_AW'(ROWS - 1)) ? '0 : clr_row_q + 1'b1;
			end
		end
	end

	// Entry result and running check status.
	logic [1:0] first_q;
	logic       ovl_q;
	logic [1:0] first_d;
	logic       ovl_d;
	logic [1:0] entry_err;
	logic [1:0] status;
	assign first_d   = ((first_q == ERR_OK) && (err_q != ERR_OK)) ? err_q : first_q;
	assign ovl_d     = ovl_q || shared_q;
	assign entry_err = (err_q != ERR_OK) ? err_q : (shared_q ? ERR_SHARED : ERR_OK);
	assign status    = (first_d != ERR_OK) ? first_d : (ovl_d ? ERR_SHARED : ERR_OK);

	logic       out_valid_q;
	logic       out_in_use_q;
	logic [1:0] out_err_q;
	logic [1:0] out_status_q;
	logic       out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= ERR_OK;
			ovl_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				first_q     <= last_q ? ERR_OK : first_d;
				ovl_q       <= last_q ? 1'b0 : ovl_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_in_use_q <= in_use_q;
			out_err_q    <= entry_err;
			out_status_q <= status;
			out_last_q   <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {3'b000, out_status_q, out_err_q, out_in_use_q};
	assign out_last  = out_last_q;

	// Status for the controller.
	always_comb begin
		stat.in_use     = in_use_q;
		stat.last       = last_q;
		stat.ptr_last   = wide_q ? PTRS_WIDE_M1 : PTRS_NARROW_M1;
		stat.clear_done = (clr_row_q == ROW_AW'(ROWS - 1));
		stat.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ===== src/directory_block_map_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory block map checker
// Checks directory entries for bounds errors and blocks shared between files.
// ----------------------------------------------------------------------------
// One directory entry is taken per item and one result item is returned for
// it. The block works on one entry at a time: an entry that is not in use
// goes straight to its result, and an entry in use is walked pointer by
// pointer, eight 16-bit or sixteen byte pointers, with one read-modify-write
// of the used-block bitmap memory per nonzero pointer in the map.
// After reset and after every last entry the bitmap is cleared one 32-bit
// row per cycle, during which no item is accepted; register writes are taken
// at any time.
module directory_block_map_checker import dbmc_pkg::*; #(
	parameter int MAP_BLOCKS = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Entry stream.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// entry_status[7:0], name_chars[71:8], ext_chars[95:72],
	// pointers_low[159:96], pointers_high[223:160]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tlast,
	// Result stream.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// entry_in_use[0], entry_error[2:1], check_status[4:3], zero[7:5]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	// Register port.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	dbmc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	dbmc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	dbmc_dp #(
		.MAP_BLOCKS(MAP_BLOCKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.stat     (stat),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

// ===== src/dbmc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory block map checker port checks
// Assertions on the top-level ports, bound to every checker instance.
// ----------------------------------------------------------------------------
module dbmc_checker import dbmc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic                  s_axis_tlast,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [1:0]            cfg_index,
	input logic [31:0]           cfg_data
);

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Entries are worked on one at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("entry accepted while another is at work");

	// An entry that is not in use reports no error.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2:1] == ERR_OK)
		else $error("error reported for an entry not in use");

	// A bounds error shows up in the check status as a bounds error.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:1] == ERR_OVERFLOW || m_axis_tdata[2:1] == ERR_DIR)
			|-> (m_axis_tdata[4:3] == ERR_OVERFLOW || m_axis_tdata[4:3] == ERR_DIR))
		else $error("bounds error missing from check status");

	// A shared block leaves the check status not clean.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:1] == ERR_SHARED |-> m_axis_tdata[4:3] != ERR_OK)
		else $error("shared block missing from check status");

endmodule

bind directory_block_map_checker dbmc_checker u_dbmc_checker (.*);

// ===== dv/directory_block_map_checker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory block map checker testbench
// Streams directory entries through the checker under a range of disk, block
// and pointer settings, predicts every result item and compares it field by
// field, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module directory_block_map_checker_test;
	import dbmc_pkg::*;

	localparam int MAP_BLOCKS       = 65536;
	localparam int RESET_CYCLES     = 10;
	// Covers the bitmap clearing pass with slack to spare.
	localparam int SETTLE_CYCLES    = 2200;
	localparam int PHASES           = 10;
	localparam int USABLE_PER_PHASE = 80;
	localparam int LONG_HOLD_AT     = 60;
	localparam int LONG_HOLD_CYCLES = 400;
	// Pointer bytes 3 to 18, byte 0 in the lowest bits.
	localparam logic [127:0] SEQ_PTRS = 128'h1211100F0E0D0C0B0A09080706050403;

	typedef struct packed {
		logic [7:0]  status;
		logic [63:0] name_chars;
		logic [23:0] ext_chars;
		logic [63:0] ptr_low;
		logic [63:0] ptr_high;
		logic        last;
	} entry_t;

	typedef struct packed {
		logic       in_use;
		logic [1:0] error_code;
		logic [1:0] status;
		logic       done;
	} entry_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// entry_status[7:0], name_chars[71:8], ext_chars[95:72],
	// pointers_low[159:96], pointers_high[223:160]
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// entry_in_use[0], entry_error[2:1], check_status[4:3], zero[7:5]
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [1:0]            cfg_index;
	logic [31:0]           cfg_data;

	// Punctuation refused in names and extensions.
	logic [7:0] refused_punct [11] = '{"<", ">", ".", ",", ";", ":", "=", "?", "*", "[", "]"};

	// Block allocation for well-formed checks.
	logic [31:0] next_free_block;
	logic [31:0] claimed_blocks [$];
	int          entries_sent;
	bit          send_burst;

	directory_block_map_checker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A character is usable unless, taken to seven bits, it is a control
	// character or refused punctuation.
	function automatic bit char_usable(input logic [7:0] c);
		logic [6:0] k;
		k = c[6:0];
		if (k < 7'h20)
			return 1'b0;
		foreach (refused_punct[i])
			if (k == refused_punct[i][6:0])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit entry_usable(input entry_t e);
		if (e.status == DELETED_MARK)
			return 1'b0;
		for (int i = 0; i < 8; i++)
			if (!char_usable(e.name_chars[8*i +: 8]))
				return 1'b0;
		for (int i = 0; i < 3; i++)
			if (!char_usable(e.ext_chars[8*i +: 8]))
				return 1'b0;
		return 1'b1;
	endfunction

	// Predicts the result item of each entry and holds the results still due.
	class block_map_scoreboard;
		logic [31:0]         disk_size_bytes;
		logic [3:0]          block_shift;
		logic [11:0]         dir_entry_count;
		logic                wide_pointers;
		bit [MAP_BLOCKS-1:0] used_blocks;
		logic [1:0]          first_bounds_error;
		bit                  overlap_seen;
		entry_result_t       pending_results [$];
		int                  failures;
		int                  results_checked;
		int                  entries_in_use;
		int                  closed_checks;
		int                  error_tally [4];

		function new();
			disk_size_bytes    = DISK_SIZE_RST;
			block_shift        = BLOCK_SHIFT_RST;
			dir_entry_count    = DIR_ENTRIES_RST;
			wide_pointers      = 1'b0;
			used_blocks        = '0;
			first_bounds_error = ERR_OK;
			overlap_seen       = 1'b0;
			failures           = 0;
			results_checked    = 0;
			entries_in_use     = 0;
			closed_checks      = 0;
			error_tally        = '{default: 0};
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [31:0] data);
			case (idx)
				REG_DISK_SIZE:   disk_size_bytes = data;
				REG_BLOCK_SHIFT: block_shift     = data[3:0];
				REG_DIR_ENTRIES: dir_entry_count = data[11:0];
				REG_WIDE_PTRS:   wide_pointers   = data[0];
			endcase
		endfunction

		function logic [31:0] max_block();
			return disk_size_bytes >> block_shift;
		endfunction

		// Directory size in blocks, rounded up.
		function logic [31:0] reserved_blocks();
			logic [31:0] bytes;
			logic [31:0] blks;
			bytes = 32'(dir_entry_count) * 32;
			blks  = bytes >> block_shift;
			if ((bytes & ((32'd1 << block_shift) - 32'd1)) != 0)
				blks++;
			return blks;
		endfunction

		function void note_entry(input entry_t e);
			entry_result_t want;
			logic [127:0]  ptrs;
			logic [31:0]   limit;
			logic [31:0]   dirb;
			logic [31:0]   p;
			bit            shared;
			int            n;
			want.in_use     = entry_usable(e);
			want.error_code = ERR_OK;
			want.done       = e.last;
			if (want.in_use) begin
				entries_in_use++;
				limit  = max_block();
				dirb   = reserved_blocks();
				ptrs   = {e.ptr_high, e.ptr_low};
				n      = wide_pointers ? 8 : 16;
				shared = 1'b0;
				// Pointers in order: the first bounds error wins; every nonzero
				// pointer is marked, and a mark already set means a shared block.
				for (int i = 0; i < n; i++) begin
					p = wide_pointers ? 32'(ptrs[16*i +: 16]) : 32'(ptrs[8*i +: 8]);
					if (want.error_code == ERR_OK) begin
						if (p > limit)
							want.error_code = ERR_OVERFLOW;
						else if (p != 0 && p < dirb)
							want.error_code = ERR_DIR;
					end
					if (p != 0 && p < MAP_BLOCKS) begin
						if (used_blocks[p[15:0]])
							shared = 1'b1;
						used_blocks[p[15:0]] = 1'b1;
					end
				end
				if (want.error_code != ERR_OK) begin
					if (first_bounds_error == ERR_OK)
						first_bounds_error = want.error_code;
				end else if (shared) begin
					want.error_code = ERR_SHARED;
				end
				if (shared)
					overlap_seen = 1'b1;
			end
			want.status = (first_bounds_error != ERR_OK) ? first_bounds_error :
				(overlap_seen ? ERR_SHARED : ERR_OK);
			error_tally[want.error_code]++;
			pending_results.push_back(want);
			// The last entry closes the check and starts a fresh map.
			if (e.last) begin
				closed_checks++;
				used_blocks        = '0;
				first_bounds_error = ERR_OK;
				overlap_seen       = 1'b0;
			end
		endfunction

		function void compare_field(input string field, input logic [31:0] want,
				input logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_result(input logic [OUT_DATA_W-1:0] data, input logic last);
			entry_result_t want;
			if (pending_results.size() == 0) begin
				$error("result item arrived with no entry waiting for it");
				failures++;
				return;
			end
			want = pending_results.pop_front();
			results_checked++;
			compare_field("entry_in_use", 32'(want.in_use), 32'(data[0]));
			compare_field("entry_error", 32'(want.error_code), 32'(data[2:1]));
			compare_field("check_status", 32'(want.status), 32'(data[4:3]));
			compare_field("padding", 32'd0, 32'(data[7:5]));
			compare_field("check_done", 32'(want.done), 32'(last));
		endfunction
	endclass

	block_map_scoreboard sb = new();

	function automatic logic [7:0] usable_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (!char_usable(c));
		return c;
	endfunction

	function automatic logic [7:0] refused_char();
		logic [7:0] c;
		if ($urandom_range(0, 2) == 0)
			c = 8'($urandom_range(0, 31));
		else
			c = refused_punct[$urandom_range(0, 10)];
		c[7] = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Character position 0 to 7 lies in the name, 8 to 10 in the extension.
	function automatic entry_t with_char(input entry_t e, input int pos, input logic [7:0] c);
		if (pos < 8)
			e.name_chars[8*pos +: 8] = c;
		else
			e.ext_chars[8*(pos-8) +: 8] = c;
		return e;
	endfunction

	function automatic entry_t usable_entry();
		entry_t e;
		e = '0;
		e.status = 8'($urandom_range(0, 15));
		if ($urandom_range(0, 7) == 0)
			e.status = 8'($urandom_range(0, 255));
		if (e.status == DELETED_MARK)
			e.status = 8'h00;
		for (int i = 0; i < 11; i++)
			e = with_char(e, i, usable_char());
		return e;
	endfunction

	function automatic void begin_check();
		logic [31:0] dirb;
		dirb = sb.reserved_blocks();
		next_free_block = (dirb == 0) ? 32'd1 : dirb;
		claimed_blocks.delete();
	endfunction

	// Hands out blocks past the directory; once they run out, any block.
	function automatic logic [31:0] fresh_pointer(input logic [31:0] limit);
		logic [31:0] p;
		if (next_free_block <= limit) begin
			p = next_free_block;
			next_free_block += sb.wide_pointers ? $urandom_range(1, 64) : $urandom_range(1, 2);
		end else begin
			p = $urandom_range(0, limit);
		end
		return p;
	endfunction

	function automatic void place_pointer(inout logic [127:0] ptrs, input int idx,
			input logic [31:0] p);
		if (sb.wide_pointers)
			ptrs[16*idx +: 16] = p[15:0];
		else
			ptrs[8*idx +: 8] = p[7:0];
		if (p != 0)
			claimed_blocks.push_back(p);
	endfunction

	// Mostly fresh blocks, now and then one overflow, directory block or repeat.
	function automatic entry_t with_pointers(input entry_t e);
		logic [127:0] ptrs;
		logic [31:0]  top;
		logic [31:0]  limit;
		logic [31:0]  dirb;
		int           n;
		int           cnt;
		int           flavour;
		int           pos;
		top   = sb.wide_pointers ? 32'hFFFF : 32'hFF;
		limit = sb.max_block();
		if (limit > top)
			limit = top;
		dirb    = sb.reserved_blocks();
		n       = sb.wide_pointers ? 8 : 16;
		cnt     = $urandom_range(0, n);
		ptrs    = '0;
		for (int i = 0; i < cnt; i++)
			place_pointer(ptrs, i, fresh_pointer(limit));
		flavour = $urandom_range(0, 99);
		pos     = $urandom_range(0, n - 1);
		if (flavour < 6 && limit < top)
			place_pointer(ptrs, pos, $urandom_range(limit + 1, top));
		else if (flavour < 12 && dirb > 1)
			place_pointer(ptrs, pos, $urandom_range(1, (dirb - 1 > top) ? top : dirb - 1));
		else if (flavour < 20 && claimed_blocks.size() > 0)
			place_pointer(ptrs, pos, claimed_blocks[$urandom_range(0, claimed_blocks.size() - 1)]);
		{e.ptr_high, e.ptr_low} = ptrs;
		return e;
	endfunction

	function automatic entry_t random_entry();
		entry_t e;
		int     kind;
		kind = $urandom_range(0, 99);
		e    = with_pointers(usable_entry());
		if (kind >= 95) begin
			e.status     = 8'($urandom_range(0, 255));
			e.name_chars = {$urandom, $urandom};
			e.ext_chars  = 24'($urandom);
		end
		if (kind >= 90) begin
			e.ptr_low  = {$urandom, $urandom};
			e.ptr_high = {$urandom, $urandom};
		end else if (kind >= 82) begin
			e.status = DELETED_MARK;
		end else if (kind >= 74) begin
			e = with_char(e, $urandom_range(0, 10), refused_char());
		end
		return e;
	endfunction

	function automatic cfg_t phase_setting(input int ph);
		cfg_t c;
		case (ph)
			0: c = '{32'd256256, 4'd10, 12'd64, 1'b0};
			1: c = '{32'd256256, 4'd10, 12'd64, 1'b1};
			2: c = '{32'hFFFF_FFFF, 4'd14, 12'd2048, 1'b1};
			3: c = '{32'd0, 4'd12, 12'd1, 1'b0};
			4: c = '{32'd1000000, 4'd12, 12'd0, 1'b1};
			5: c = '{32'd70000000, 4'd10, 12'd2048, 1'b1};
			6: c = '{32'd300000, 4'd8, 12'd100, 1'b0};
			7: c = '{32'd180000, 4'd13, 12'd5, 1'b0};
			8: c = '{$urandom, 4'($urandom_range(10, 14)), 12'($urandom_range(1, 2048)),
				1'($urandom_range(0, 1))};
			default: c = '{32'($urandom_range(0, 400000)), 4'($urandom_range(10, 14)),
				12'($urandom_range(1, 2048)), 1'b0};
		endcase
		return c;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(input cfg_t c);
		write_reg(REG_DISK_SIZE, c.disk_size_bytes);
		write_reg(REG_BLOCK_SHIFT, 32'(c.block_shift));
		write_reg(REG_DIR_ENTRIES, 32'(c.dir_entry_count));
		write_reg(REG_WIDE_PTRS, 32'(c.wide_pointers));
	endtask

	// Offers one entry after a random gap; valid stays high into the next item.
	task automatic send_entry(input entry_t e);
		int gap;
		@(negedge clk);
		gap = send_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {e.ptr_high, e.ptr_low, e.ext_chars, e.name_chars, e.status};
		s_axis_tlast  <= e.last;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		sb.note_entry(e);
		entries_sent++;
		if (entries_sent % 64 == 0)
			send_burst = ($urandom_range(0, 3) == 0);
	endtask

	// Stops offering, waits for every result and for the clearing pass.
	task automatic drain_and_settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Field extremes, each error kind, deleted entries and refused characters.
	task automatic run_directed();
		entry_t     e;
		logic [7:0] c;
		e = '0;
		send_entry(e);
		e = '1;
		e.last = 1'b0;
		send_entry(e);
		e = usable_entry();
		e.status = DELETED_MARK;
		{e.ptr_high, e.ptr_low} = SEQ_PTRS;
		send_entry(e);
		e = usable_entry();
		{e.ptr_high, e.ptr_low} = SEQ_PTRS;
		send_entry(e);
		e = usable_entry();
		{e.ptr_high, e.ptr_low} = 128'h01;
		send_entry(e);
		e = usable_entry();
		{e.ptr_high, e.ptr_low} = 128'h07;
		e.last = 1'b1;
		send_entry(e);
		// Two pointers of one entry on the same block.
		e = usable_entry();
		{e.ptr_high, e.ptr_low} = 128'h0303;
		send_entry(e);
		// Overflow ahead of a directory block, then the other way round.
		e = usable_entry();
		{e.ptr_high, e.ptr_low} = 128'h01FB;
		send_entry(e);
		e = usable_entry();
		{e.ptr_high, e.ptr_low} = 128'hFB01;
		e.last = 1'b1;
		send_entry(e);
		// Each refused character, each character position.
		for (int k = 0; k < 14; k++) begin
			case (k)
				11:      c = 8'h1F;
				12:      c = 8'h9F;
				13:      c = 8'hBC;
				default: c = refused_punct[k];
			endcase
			e = with_char(usable_entry(), k % 11, c);
			e.last = (k == 13);
			send_entry(e);
		end
	endtask

	// Whole checks of random length until enough entries in use have gone in.
	task automatic run_random_checks(input int usable_budget);
		entry_t e;
		int     usable;
		int     len;
		usable = 0;
		while (usable < usable_budget) begin
			len = $urandom_range(1, 40);
			begin_check();
			for (int j = 0; j < len; j++) begin
				e = random_entry();
				e.last = (j == len - 1);
				if (entry_usable(e))
					usable++;
				send_entry(e);
			end
		end
	endtask

	// Stimulus and verdict.
	initial begin : stimulus
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_DISK_SIZE;
		cfg_data      = '0;
		entries_sent  = 0;
		send_burst    = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		drain_and_settle();
		for (int ph = 0; ph < PHASES; ph++) begin
			apply_setting(phase_setting(ph));
			run_random_checks(USABLE_PER_PHASE);
			drain_and_settle();
		end
		$display("Checked %0d entries (%0d in use) in %0d checks over %0d register settings.",
			sb.results_checked, sb.entries_in_use, sb.closed_checks, PHASES + 1);
		$display("Entry errors: %0d overflow, %0d directory overlap, %0d shared; %0d mismatches.",
			sb.error_tally[ERR_OVERFLOW], sb.error_tally[ERR_DIR], sb.error_tally[ERR_SHARED],
			sb.failures);
		if (sb.failures == 0 && sb.pending_results.size() == 0)
			$display("directory_block_map_checker test passed");
		else
			$display("directory_block_map_checker test failed");
		$finish;
	end

	// Result stream: random stalls, bursts without stalls and one long hold-off.
	initial begin : result_sink
		int gap;
		int seen;
		bit burst;
		seen          = 0;
		burst         = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (seen == LONG_HOLD_AT)
				gap = LONG_HOLD_CYCLES;
			else
				gap = burst ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			sb.check_result(m_axis_tdata, m_axis_tlast);
			seen++;
			if (seen % 50 == 0)
				burst = ($urandom_range(0, 3) == 0);
		end
	end

	// Watchdog.
	initial begin : watchdog
		#20ms;
		$display("directory_block_map_checker test failed");
		$finish;
	end

endmodule
